// File: hw/rtl/text_terminal_cell_writer_macros.svh
// Assertion macros for the text terminal cell writer checker.
// No dependencies; the including scope provides clk and rst_n.
`ifndef TEXT_TERMINAL_CELL_WRITER_MACROS_SVH
`define TEXT_TERMINAL_CELL_WRITER_MACROS_SVH

// check while out of reset
`define TTCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ttcw assertion failed");

// check on every edge, reset included
`define TTCW_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ttcw assertion failed");

`endif

// File: hw/rtl/ttcw_pkg.sv
// Shared types and constants of the text terminal cell writer.
// No dependencies.
package ttcw_pkg;

  localparam int CELL_ADDR_W = 15;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [3:0] FG_RESET     = 4'h7;
  localparam logic [3:0] BG_RESET     = 4'h0;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PUT       = 2'd0,
    FUNC_BACKSPACE = 2'd1,
    FUNC_CLEAR     = 2'd2,
    FUNC_READ      = 2'd3
  } func_e_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } out_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
  } cfg_t;

  typedef struct packed {
    logic                   we;
    logic [CELL_ADDR_W-1:0] waddr;
    logic [15:0]            wdata;
    logic [CELL_ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: hw/rtl/ttcw_mem.sv
// Screen cell memory: one write port, one read port, registered read data.
// Depends on ttcw_pkg.
module ttcw_mem
  import ttcw_pkg::*;
#(
  parameter int DEPTH = 2000
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0] cells [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata_r <= cells[req.raddr[AW-1:0]];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ttcw_ctrl.sv
// Sequencer of the cell writer: cursor, put/backspace/read, scroll and fill sweeps,
// result register. Depends on ttcw_pkg; drives ttcw_mem through mem_req_t.
module ttcw_ctrl
  import ttcw_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  cfg_t        cfg,
  output mem_req_t    mem_req,
  input  logic [15:0] mem_rdata
);

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLS);
  localparam int CW    = $clog2(CELLS + 1);

  localparam logic [RW-1:0]  ROW_LAST   = RW'(ROWS - 1);
  localparam logic [CLW-1:0] COL_LAST   = CLW'(COLS - 1);
  localparam logic [CW-1:0]  CNT_LAST   = CW'(CELLS - 1);
  localparam logic [CW-1:0]  CNT_END    = CW'(CELLS);
  localparam logic [CW-1:0]  CNT_COLS   = CW'(COLS);
  localparam logic [CW-1:0]  CNT_BOTTOM = CW'(CELLS - COLS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  func_e_t        func_r, func_nxt;
  logic [7:0]     char_r, char_nxt;
  logic [10:0]    idx_r, idx_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           cp_valid_r, cp_valid_nxt;
  logic [CW-1:0]  cp_addr_r, cp_addr_nxt;
  logic           scrolled_r, scrolled_nxt;
  logic [15:0]    word_r, word_nxt;
  logic           emit_r, emit_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_data_r, out_data_nxt;

  logic [CW-1:0]  pos_cur;
  logic [15:0]    blank;
  logic [15:0]    put_cell;

  assign pos_cur  = CW'(CW'(row_r) * CNT_COLS) + CW'(col_r);
  assign blank    = emit_r ? {cfg.bg, cfg.fg, CHAR_SPACE} : {BG_RESET, FG_RESET, CHAR_SPACE};
  assign put_cell = {cfg.bg, cfg.fg, char_r};

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    char_nxt      = char_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    cp_valid_nxt  = cp_valid_r;
    cp_addr_nxt   = cp_addr_r;
    scrolled_nxt  = scrolled_r;
    word_nxt      = word_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt     = func_e_t'(in_data.func);
          char_nxt     = in_data.char_code;
          idx_nxt      = in_data.cell_index;
          scrolled_nxt = 1'b0;
          word_nxt     = '0;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (func_r)
          FUNC_PUT: begin
            if (char_r != CHAR_NEWLINE) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = CELL_ADDR_W'(pos_cur);
              mem_req.wdata = put_cell;
            end
            if (char_r == CHAR_NEWLINE || col_r == COL_LAST) begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                scrolled_nxt = 1'b1;
                cnt_nxt      = CNT_COLS;
                cp_valid_nxt = 1'b0;
                state_nxt    = S_SCROLL;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
          FUNC_BACKSPACE: begin
            if (pos_cur != '0) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = CELL_ADDR_W'(pos_cur - 1'b1);
              mem_req.wdata = blank;
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end else begin
                row_nxt = row_r - 1'b1;
                col_nxt = COL_LAST;
              end
            end
          end
          FUNC_CLEAR: begin
            row_nxt   = '0;
            col_nxt   = '0;
            cnt_nxt   = '0;
            emit_nxt  = 1'b1;
            state_nxt = S_FILL;
          end
          default: begin
            if (32'(idx_r) < CELLS) begin
              mem_req.raddr = CELL_ADDR_W'(idx_r);
              state_nxt     = S_READ;
            end
          end
        endcase
      end
      S_READ: begin
        word_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        if (cp_valid_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = CELL_ADDR_W'(cp_addr_r);
          mem_req.wdata = mem_rdata;
        end
        if (cnt_r == CNT_END) begin
          cp_valid_nxt = 1'b0;
          cnt_nxt      = CNT_BOTTOM;
          emit_nxt     = 1'b1;
          state_nxt    = S_FILL;
        end else begin
          mem_req.raddr = CELL_ADDR_W'(cnt_r);
          cp_valid_nxt  = 1'b1;
          cp_addr_nxt   = cnt_r - CNT_COLS;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = CELL_ADDR_W'(cnt_r);
        mem_req.wdata = blank;
        if (cnt_r == CNT_LAST) begin
          state_nxt = emit_r ? S_DONE : S_IDLE;
          emit_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cell_word  = word_r;
          out_data_nxt.cursor_row = 5'(row_r);
          out_data_nxt.cursor_col = 7'(col_r);
          out_data_nxt.scrolled   = scrolled_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      cp_valid_r  <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      cp_valid_r  <= cp_valid_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    char_r     <= char_nxt;
    idx_r      <= idx_nxt;
    cp_addr_r  <= cp_addr_nxt;
    scrolled_r <= scrolled_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/text_terminal_cell_writer.sv
// Text terminal cell writer: put, newline, backspace and read go from accept through EXEC
// (read also READ) to DONE, which registers the result beat; one item in flight, a new
// beat taken only after DONE. Scroll (past the last row) and clear sweep the cell memory
// through its single write port.
// Reset: synchronous; a fill sweep blanks the store in the reset colours, in_ready low meanwhile.
// Depends on ttcw_pkg, ttcw_ctrl and ttcw_mem.
module text_terminal_cell_writer
  import ttcw_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg_r, cfg_nxt;
  mem_req_t    mem_req;
  logic [15:0] mem_rdata;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FG:  cfg_nxt.fg = pwdata[3:0];
        default: cfg_nxt.bg = pwdata[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg <= FG_RESET;
      cfg_r.bg <= BG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = {28'd0, (paddr[2] == REG_BG) ? cfg_r.bg : cfg_r.fg};

  ttcw_ctrl #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg      (cfg_r),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  ttcw_mem #(
    .DEPTH(ROWS * COLS)
  ) u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

endmodule

// File: hw/rtl/ttcw_checker.sv
// Port-level checks of the text terminal cell writer, bound to the top level.
// Depends on ttcw_pkg and text_terminal_cell_writer_macros.svh.
`include "text_terminal_cell_writer_macros.svh"

module ttcw_checker
  import ttcw_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `TTCW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `TTCW_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)
  `TTCW_ASSERT(a_scroll_col_zero, out_valid && out_data.scrolled |-> out_data.cursor_col == 7'd0)
  `TTCW_ASSERT_ANY(a_rst_no_beat, !rst_n |=> !out_valid)
  `TTCW_ASSERT_ANY(a_rst_fill_busy, !rst_n |=> !in_ready)

endmodule

bind text_terminal_cell_writer ttcw_checker u_ttcw_checker (.*);

// File: tb/ttcw_screen_checker.sv
`timescale 1ns / 100ps
// Screen checker for the text terminal cell writer: mirrors the cell store, cursor and colour
// registers, predicts each result beat and compares it field by field with the block's output.
// Depends on ttcw_pkg; watches the command, result and register ports only.
module ttcw_screen_checker
  import ttcw_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          status_pending
);

  localparam int CELLS = ROWS * COLS;

  logic [15:0] screen [CELLS];
  int          cur_row;
  int          cur_col;
  logic [3:0]  fg_reg;
  logic [3:0]  bg_reg;
  out_t        predicted_status [$];
  int          errors = 0;

  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = {bg_reg, fg_reg, CHAR_SPACE};
    cur_row = 0;
    cur_col = 0;
  endtask

  task automatic predict_terminal_op(input in_t cmd, output out_t status);
    logic [15:0] word;
    logic        did_scroll;
    logic        moved;
    word = '0;
    did_scroll = 1'b0;
    moved = 1'b1;
    case (func_e_t'(cmd.func))
      FUNC_PUT: begin
        if (cmd.char_code != CHAR_NEWLINE) begin
          screen[cur_row * COLS + cur_col] = {bg_reg, fg_reg, cmd.char_code};
          cur_col++;
        end
        if (cmd.char_code == CHAR_NEWLINE || cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {bg_reg, fg_reg, CHAR_SPACE};
            cur_row = ROWS - 1;
            did_scroll = 1'b1;
          end
        end
      end
      FUNC_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
        end else begin
          moved = 1'b0;
        end
        if (moved) screen[cur_row * COLS + cur_col] = {bg_reg, fg_reg, CHAR_SPACE};
      end
      FUNC_CLEAR: begin
        blank_screen();
      end
      default: begin
        if (int'(cmd.cell_index) < CELLS) word = screen[cmd.cell_index];
      end
    endcase
    status.cell_word  = word;
    status.cursor_row = 5'(cur_row);
    status.cursor_col = 7'(cur_col);
    status.scrolled   = did_scroll;
  endtask

  task automatic flag_field(input string name, input logic [15:0] want, input logic [15:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    out_t got;
    if (!rst_n) begin
      fg_reg = FG_RESET;
      bg_reg = BG_RESET;
      blank_screen();
      predicted_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (predicted_status.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got);
          errors++;
        end else begin
          want = predicted_status.pop_front();
          if (got.cell_word !== want.cell_word)
            flag_field("cell_word", want.cell_word, got.cell_word);
          if (got.cursor_row !== want.cursor_row)
            flag_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
          if (got.cursor_col !== want.cursor_col)
            flag_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
          if (got.scrolled !== want.scrolled)
            flag_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_BG) bg_reg = pwdata[3:0];
        else fg_reg = pwdata[3:0];
      end
      if (in_valid && in_ready) begin
        predict_terminal_op(in_data, want);
        predicted_status.push_back(want);
      end
    end
    mismatch_count <= errors;
    status_pending <= predicted_status.size();
  end

endmodule

// File: tb/text_terminal_cell_writer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the text terminal cell writer: resets the block, drives command beats and
// colour register writes under varying idle patterns, and gives the verdict.
// Depends on ttcw_pkg, the block and ttcw_screen_checker.
module text_terminal_cell_writer_tb;
  import ttcw_pkg::*;

  localparam int ROWS        = 25;
  localparam int COLS        = 80;
  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_LIMIT = 200000;
  localparam logic [2:0] ADDR_FG = {REG_FG, 2'b00};
  localparam logic [2:0] ADDR_BG = {REG_BG, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int status_pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_terminal_cell_writer #(.ROWS(ROWS), .COLS(COLS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ttcw_screen_checker #(.ROWS(ROWS), .COLS(COLS)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .status_pending(status_pending)
  );

  initial begin : rx_drive
    int k;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        holds_done++;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_cmd(input func_e_t f, input logic [7:0] ch, input logic [10:0] idx);
    in_t beat;
    beat.func       = f;
    beat.char_code  = ch;
    beat.cell_index = idx;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_and_recolor(input logic [3:0] fg, input logic [3:0] bg);
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_pending != 0) @(posedge clk);
    write_reg(ADDR_FG, fg);
    write_reg(ADDR_BG, bg);
  endtask

  task automatic run_traffic(input int n_items);
    int          sent;
    int          kind;
    int          len;
    logic [7:0]  ch;
    logic [10:0] idx;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) len = $urandom_range(1, 90);
      else if (kind < 62) len = $urandom_range(1, 4);
      else if (kind < 72) len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                            : $urandom_range(1, 5);
      else if (kind < 80) len = $urandom_range(1, 30);
      else if (kind < 82) len = 1;
      else len = $urandom_range(1, 3);
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) begin
        ch  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(32, 126));
        idx = 11'($urandom_range(0, 2047));
        if (kind < 50) begin
          send_cmd(FUNC_PUT, ch, idx);
        end else if (kind < 62) begin
          case ($urandom_range(0, 3))
            0, 1: idx = 11'($urandom_range(0, ROWS * COLS - 1));
            2: idx = 11'($urandom_range((ROWS - 2) * COLS, ROWS * COLS - 1));
            default: idx = 11'($urandom_range(0, 2047));
          endcase
          send_cmd(FUNC_READ, 8'($urandom_range(0, 255)), idx);
        end else if (kind < 72) begin
          send_cmd(FUNC_BACKSPACE, 8'($urandom_range(0, 255)), idx);
        end else if (kind < 80) begin
          send_cmd(FUNC_PUT, CHAR_NEWLINE, idx);
        end else if (kind < 82) begin
          send_cmd(FUNC_CLEAR, 8'($urandom_range(0, 255)), idx);
        end else begin
          send_cmd(func_e_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), idx);
        end
        sent++;
      end
      if (kind < 50 && $urandom_range(0, 9) < 7) begin
        send_cmd(FUNC_PUT, CHAR_NEWLINE, 11'($urandom_range(0, 2047)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int wait_cnt;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 10;
    rx_idle_pct = 87;
    send_cmd(FUNC_BACKSPACE, 8'hFF, 11'h7FF);
    send_cmd(FUNC_READ, 8'h00, 11'd0);
    send_cmd(FUNC_READ, 8'hFF, 11'd1999);
    send_cmd(FUNC_READ, 8'h00, 11'd2000);
    send_cmd(FUNC_READ, 8'hFF, 11'h7FF);
    send_cmd(FUNC_PUT, 8'h00, 11'h7FF);
    send_cmd(FUNC_PUT, 8'hFF, 11'd0);
    send_cmd(FUNC_PUT, CHAR_NEWLINE, 11'd0);
    send_cmd(FUNC_BACKSPACE, 8'h00, 11'd0);
    send_cmd(FUNC_READ, 8'h00, 11'd79);
    send_cmd(FUNC_PUT, 8'h41, 11'd0);
    send_cmd(FUNC_READ, 8'h00, 11'd79);
    send_cmd(FUNC_READ, 8'h00, 11'd1);
    send_cmd(FUNC_PUT, 8'h09, 11'd0);
    send_cmd(FUNC_PUT, 8'h7F, 11'd0);
    send_cmd(FUNC_BACKSPACE, 8'hFF, 11'h7FF);
    send_cmd(FUNC_READ, 8'h00, 11'd81);
    send_cmd(FUNC_CLEAR, 8'hFF, 11'h7FF);
    send_cmd(FUNC_READ, 8'h00, 11'd0);
    send_cmd(FUNC_READ, 8'h00, 11'd80);
    run_traffic(PHASE_ITEMS);

    drain_and_recolor(4'h0, 4'hF);
    tx_idle_pct = 87;
    rx_idle_pct = 10;
    send_cmd(FUNC_PUT, 8'h5A, 11'd0);
    send_cmd(FUNC_BACKSPACE, 8'h00, 11'd0);
    run_traffic(PHASE_ITEMS);

    drain_and_recolor(4'hF, 4'h0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(PHASE_ITEMS / 2);
    hold_reqs++;
    run_traffic(PHASE_ITEMS / 2);

    drain_and_recolor(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    send_cmd(FUNC_CLEAR, 8'h00, 11'd0);
    run_traffic(PHASE_ITEMS);

    in_valid <= 1'b0;
    @(posedge clk);
    wait_cnt = 0;
    while (status_pending != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && status_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ttcw_pkg.sv
hw/rtl/ttcw_mem.sv
hw/rtl/ttcw_ctrl.sv
hw/rtl/text_terminal_cell_writer.sv
hw/rtl/ttcw_checker.sv
tb/ttcw_screen_checker.sv
tb/text_terminal_cell_writer_tb.sv
